### hw/rtl/ksm_pkg.sv
// Shared types and constants of the kth-smallest sorted matrix block.
// No dependencies.
package ksm_pkg;
	localparam int MaxDim    = 16;
	localparam int DimW      = $clog2(MaxDim);        // row / column index width
	localparam int AddrW     = 2 * DimW;              // store address width
	localparam int CntW      = DimW + 1;              // counts up to MaxDim
	localparam int ValW      = 32;
	localparam int RankW     = 16;

	localparam logic [1:0] StOk     = 2'd0;
	localparam logic [1:0] StRankLo = 2'd1;
	localparam logic [1:0] StRankHi = 2'd2;

	localparam logic OpLoad  = 1'b0;
	localparam logic OpQuery = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load_wr;     // write element at load pointer
		logic ptr_clr;     // reset load pointer
		logic q_start;     // latch rank, clear row heads
		logic scan_clr;    // start a new scan over the rows
		logic scan_rd;     // issue read for current scan row
		logic scan_acc;    // compare returned read data
		logic pop;         // advance the winning row
		logic res_zero;    // rank-zero result
		logic res_load;    // load result register from merge
	} ksm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;   // current scan row is the last in the merge
		logic steps_done;  // all merge steps taken
		logic rank_zero;
		logic found;       // a head was found during the scan
	} ksm_sts_t;
endpackage

### hw/rtl/ksm_datapath.sv
// Datapath: element store, load pointer, row heads and merge scan.
// Depends on ksm_pkg.
module ksm_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ksm_pkg::ksm_cmd_t          cmd,
	output ksm_pkg::ksm_sts_t          sts,
	input  logic [4:0]                 matrix_dim,
	input  logic signed [31:0]         element_value,
	input  logic [15:0]                rank,
	output logic signed [31:0]         res_value,
	output logic [1:0]                 res_status
);
	import ksm_pkg::*;

	logic [ValW-1:0]  mem [MaxDim*MaxDim];
	logic [ValW-1:0]  rd_q;
	logic [CntW-1:0]  dim;
	logic [2*CntW-1:0] total;
	logic [AddrW:0]   ptr_q;
	logic [RankW-1:0] k_q;
	logic [CntW-1:0]  col_q [MaxDim];
	logic [CntW-1:0]  nrows;
	logic [DimW-1:0]  row_q, rd_row_q, best_q;
	logic             rd_ok_q, found_q;
	logic signed [ValW-1:0] best_val_q, res_q;
	logic [RankW:0]   step_q;
	logic [RankW:0]   steps;
	logic [1:0]       st_q;
	logic [AddrW-1:0] rd_addr;
	logic [AddrW-1:0] wr_addr;

	// clamp dimension to 1..MaxDim
	always_comb begin
		if (matrix_dim == '0)
			dim = CntW'(1);
		else if (matrix_dim > 5'(MaxDim))
			dim = CntW'(MaxDim);
		else
			dim = CntW'(matrix_dim);
	end
	assign total = dim * dim;
	assign nrows = ({1'b0, k_q} < (RankW+1)'(dim)) ? CntW'(k_q) : dim;
	assign steps = ((RankW+1)'(k_q) < (RankW+1)'(total)) ? (RankW+1)'(k_q)
		: (RankW+1)'(total);
	assign rd_addr = AddrW'(row_q) * AddrW'(dim) + AddrW'(col_q[row_q]);
	assign wr_addr = ptr_q[AddrW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_wr)
			mem[wr_addr] <= element_value;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			found_q <= 1'b0;
			rd_ok_q <= 1'b0;
			step_q  <= '0;
		end else begin
			if (cmd.ptr_clr)
				ptr_q <= '0;
			else if (cmd.load_wr)
				ptr_q <= (ptr_q + 1'b1 == (AddrW+1)'(total)) ? '0 : ptr_q + 1'b1;
			if (cmd.q_start)
				step_q <= '0;
			else if (cmd.pop)
				step_q <= step_q + 1'b1;
			if (cmd.scan_clr)
				found_q <= 1'b0;
			else if (cmd.scan_acc && rd_ok_q &&
				(!found_q || $signed(rd_q) < best_val_q))
				found_q <= 1'b1;
			// no read in flight on the first scan cycle
			if (cmd.scan_clr)
				rd_ok_q <= 1'b0;
			else if (cmd.scan_rd)
				rd_ok_q <= col_q[row_q] < dim;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			k_q <= rank;
			for (int i = 0; i < MaxDim; i++)
				col_q[i] <= '0;
		end
		if (cmd.scan_clr)
			row_q <= '0;
		else if (cmd.scan_rd)
			row_q <= row_q + 1'b1;
		if (cmd.scan_rd)
			rd_row_q <= row_q;
		if (cmd.scan_acc && rd_ok_q && (!found_q || $signed(rd_q) < best_val_q)) begin
			best_val_q <= rd_q;
			best_q     <= rd_row_q;
		end
		if (cmd.pop) begin
			col_q[best_q] <= col_q[best_q] + 1'b1;
			res_q         <= best_val_q;
		end
		if (cmd.res_zero) begin
			res_q <= '1;
			st_q  <= StRankLo;
		end else if (cmd.res_load)
			st_q <= ((RankW+1)'(k_q) > (RankW+1)'(total)) ? StRankHi : StOk;
	end

	assign sts.scan_last  = (CntW'(row_q) + 1'b1) >= nrows;
	assign sts.steps_done = step_q >= steps;
	assign sts.rank_zero  = (k_q == '0);
	assign sts.found      = found_q;
	assign res_value  = res_q;
	assign res_status = st_q;
endmodule

### hw/rtl/ksm_ctrl.sv
// Controller state machine sequencing loads and the merge of a query.
// Depends on ksm_pkg.
module ksm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              opcode,
	input  logic              cfg_valid,
	output logic              out_valid,
	input  logic              out_stall,
	output ksm_pkg::ksm_cmd_t cmd,
	input  ksm_pkg::ksm_sts_t sts
);
	import ksm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_ACC  = 3'd3;
	localparam logic [2:0] S_POP  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic       ov_q;
	logic       acc;

	// new item only when idle and any previous result has been taken or will be
	assign in_stall = (state_q != S_IDLE) || (ov_q && out_stall);
	assign acc      = in_valid && !in_stall;
	assign out_valid = ov_q;

	always_comb begin
		cmd = '0;
		cmd.load_wr  = acc && (opcode == OpLoad);
		cmd.ptr_clr  = cfg_valid;
		cmd.q_start  = acc && (opcode == OpQuery);
		cmd.scan_clr = (state_q == S_CHK) || (state_q == S_POP);
		cmd.scan_rd  = (state_q == S_SCAN);
		cmd.scan_acc = (state_q == S_ACC) || (state_q == S_SCAN);
		cmd.pop      = (state_q == S_POP) && sts.found;
		cmd.res_zero = (state_q == S_CHK) && sts.rank_zero;
		cmd.res_load = (state_q == S_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && !out_stall)
				ov_q <= 1'b0;
			case (state_q)
				S_IDLE: if (cmd.q_start) state_q <= S_CHK;
				S_CHK: begin
					if (sts.rank_zero) begin
						state_q <= S_IDLE;
						ov_q    <= 1'b1;
					end else if (sts.steps_done)
						state_q <= S_DONE;
					else
						state_q <= S_SCAN;
				end
				S_SCAN: if (sts.scan_last) state_q <= S_ACC;
				S_ACC:  state_q <= S_POP;
				S_POP: begin
					if (!sts.found)
						state_q <= S_DONE;
					else
						state_q <= S_CHK;
				end
				S_DONE: begin
					state_q <= S_IDLE;
					ov_q    <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hw/rtl/kth_smallest_sorted_matrix_top.sv
// Top level of the kth-smallest sorted matrix block.
// Depends on ksm_pkg, ksm_ctrl and ksm_datapath.
//
// Usage:
//  - cfg_valid/cfg_ready write matrix_dim (clamped to 1..16) and rewind the
//    load pointer. Write only while idle.
//  - Input requests: opcode 0 stores element_value at the next row-major slot
//    (no result); opcode 1 asks for the rank-th smallest element.
//  - One result request per query on selected_value/status.
//  - A query takes min(k,d*d) merge steps, r = min(k,d) rows: each merge step
//    scans the row heads through the single read port of the element store,
//    one row per cycle.
//  - Rank zero is answered from the check state, without a merge, with -1, status 1.
//  - The result sits in an output register; in_stall stays high while a
//    query runs or while an unaccepted result is stalled by the receiver.
//  - Reset clears matrix_dim to 1, the load pointer and all control state;
//    the element store is undefined until written.
module kth_smallest_sorted_matrix_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic signed [31:0] element_value,
	input  logic [15:0]        rank,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] selected_value,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data
);
	import ksm_pkg::*;

	ksm_cmd_t   cmd;
	ksm_sts_t   sts;
	logic [4:0] dim_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dim_q <= 5'd1;
		else if (cfg_valid)
			dim_q <= cfg_data;
	end

	ksm_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .cfg_valid,
		.out_valid, .out_stall, .cmd, .sts
	);

	ksm_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .matrix_dim(dim_q), .element_value, .rank,
		.res_value(selected_value), .res_status(status)
	);

	// a load never produces a result
	a_load_no_res: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && opcode == OpLoad && !out_valid) |=> !out_valid)
		else $error("load produced result");
	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(selected_value)))
		else $error("result dropped");
	// status code stays in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != 2'd3))
		else $error("bad status");
endmodule

### sim/kth_smallest_sorted_matrix_top_tb.sv
// Self-checking testbench for kth_smallest_sorted_matrix_top: loads row-sorted matrices,
// issues rank queries and checks every result against table expectations or an in-bench rank-selection predictor.
// Depends on ksm_pkg and the kth_smallest_sorted_matrix_top RTL.
module kth_smallest_sorted_matrix_top_tb;
	import ksm_pkg::*;

	localparam int CellCount  = MaxDim * MaxDim;
	localparam int CycleLimit = 30000000;
	localparam int SettleGap  = 20;   // covers a load still in flight after the last result

	typedef struct {
		logic        op;
		logic [31:0] val;
		logic [15:0] k;
		bit          typed;      // expectation written in the table
		logic [31:0] exp_val;
		logic [1:0]  exp_st;
	} stim_row_t;

	typedef struct {
		logic [31:0] val;
		logic [1:0]  st;
	} answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               opcode = OpLoad;
	logic signed [31:0] element_value = '0;
	logic [15:0]        rank = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] selected_value;
	logic [1:0]         status;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [4:0]         cfg_data = '0;

	// predictor state
	logic [31:0] cell_mirror [CellCount];
	int unsigned fill_pos;
	logic [4:0]  dim_reg;
	answer_t     pending_answers [$];

	int unsigned sender_idle_pct;
	int unsigned stall_pct;
	int unsigned mismatches;
	int unsigned cycles;

	kth_smallest_sorted_matrix_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.element_value  (element_value),
		.rank           (rank),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.selected_value (selected_value),
		.status         (status),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Out-of-range dimensions clamp: 0 behaves as 1, anything above MaxDim as MaxDim.
	function automatic int unsigned side_len();
		if (dim_reg == 0)
			return 1;
		if (dim_reg > MaxDim)
			return MaxDim;
		return dim_reg;
	endfunction

	// k-way merge over the first min(k, d) rows; ties go to the lowest row.
	function automatic answer_t select_kth(input int unsigned k);
		answer_t     a;
		int unsigned d;
		int unsigned total;
		int unsigned rows;
		int unsigned steps;
		int unsigned col [MaxDim];
		int unsigned best_row;
		logic signed [31:0] best;
		logic signed [31:0] v;
		bit          found;
		d     = side_len();
		total = d * d;
		a.val = '0;
		if (k == 0) begin
			a.val = 32'hFFFF_FFFF;
			a.st  = StRankLo;
			return a;
		end
		rows  = (k < d) ? k : d;
		steps = (k < total) ? k : total;
		for (int r = 0; r < MaxDim; r++)
			col[r] = 0;
		for (int s = 0; s < steps; s++) begin
			found    = 1'b0;
			best_row = 0;
			best     = '0;
			for (int r = 0; r < rows; r++) begin
				if (col[r] < d) begin
					v = cell_mirror[(r * d + col[r]) % CellCount];
					if (!found || v < best) begin
						found    = 1'b1;
						best     = v;
						best_row = r;
					end
				end
			end
			if (!found)
				break;
			a.val = cell_mirror[(best_row * d + col[best_row]) % CellCount];
			col[best_row]++;
		end
		a.st = (k > total) ? StRankHi : StOk;
		return a;
	endfunction

	// Present one request, hold it through any stall, then update the mirror or queue the expected answer.
	task automatic send_request(input logic op, input logic [31:0] val, input logic [15:0] k,
			input bit typed, input answer_t typed_ans);
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid      <= 1'b1;
		opcode        <= op;
		element_value <= val;
		rank          <= k;
		do
			@(posedge clk);
		while (in_stall);
		if (op == OpLoad) begin
			cell_mirror[fill_pos % CellCount] = val;
			fill_pos = (fill_pos + 1) % (side_len() * side_len());
		end else if (typed) begin
			pending_answers.push_back(typed_ans);
		end else begin
			pending_answers.push_back(select_kth(k));
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		wait (pending_answers.size() == 0);
		repeat (SettleGap) @(posedge clk);
	endtask

	// Register write while idle; also rewinds the load pointer.
	task automatic write_dim(input logic [4:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		dim_reg   = value;
		fill_pos  = 0;
	endtask

	// Full matrix, each row sorted; narrow ranges give plenty of duplicates.
	task automatic load_sorted_matrix();
		int unsigned d;
		int          row_vals [$];
		bit          narrow;
		answer_t     none;
		d    = side_len();
		none = '{default: '0};
		for (int r = 0; r < d; r++) begin
			row_vals.delete();
			narrow = ($urandom_range(2) == 0);
			for (int c = 0; c < d; c++)
				row_vals.push_back(narrow ? $urandom_range(6) - 3 : int'($urandom()));
			row_vals.sort();
			foreach (row_vals[i])
				send_request(OpLoad, row_vals[i], '0, 1'b0, none);
		end
	endtask

	// Result checker and receiver stall generator.
	always @(posedge clk) begin
		answer_t want;
		if (out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %h status %0d", selected_value, status);
			end else begin
				want = pending_answers.pop_front();
				if (selected_value !== want.val || status !== want.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %h/%0d, got %h/%0d",
							want.val, want.st, selected_value, status);
				end
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("kth_smallest_sorted_matrix_top verification failed");
			$finish;
		end
	end

	initial begin
		stim_row_t   table_rows [$];
		logic [4:0]  dim_plan [10];
		answer_t     typed_ans;
		int unsigned d;
		int unsigned budget;
		int unsigned k;
		mismatches      = 0;
		cycles          = 0;
		fill_pos        = 0;
		dim_reg         = 5'd1;
		sender_idle_pct = 0;
		stall_pct       = 0;
		dim_plan        = '{5'd31, 5'd0, 5'd3, 5'd16, 5'd2, 5'd5, 5'd1, 5'd8, 5'd4, 5'd7};

		// Directed rows, all at the reset dimension of one.
		table_rows = '{
			'{OpLoad,  32'h7FFF_FFFF, 16'd0,     1'b0, 32'h0,         StOk},
			'{OpQuery, 32'hFFFF_FFFF, 16'd0,     1'b1, 32'hFFFF_FFFF, StRankLo},
			'{OpQuery, 32'h0,         16'd1,     1'b1, 32'h7FFF_FFFF, StOk},
			'{OpQuery, 32'h0,         16'hFFFF,  1'b1, 32'h7FFF_FFFF, StRankHi},
			'{OpLoad,  32'h8000_0000, 16'hFFFF,  1'b0, 32'h0,         StOk},
			'{OpQuery, 32'h0,         16'd1,     1'b1, 32'h8000_0000, StOk},
			'{OpQuery, 32'h0,         16'd2,     1'b1, 32'h8000_0000, StRankHi},
			'{OpLoad,  32'h0,         16'd0,     1'b0, 32'h0,         StOk},
			'{OpQuery, 32'h0,         16'd1,     1'b1, 32'h0,         StOk},
			'{OpLoad,  32'hFFFF_FFFF, 16'd0,     1'b0, 32'h0,         StOk},
			'{OpQuery, 32'h0,         16'h8000,  1'b1, 32'hFFFF_FFFF, StRankHi}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i]) begin
			typed_ans.val = table_rows[i].exp_val;
			typed_ans.st  = table_rows[i].exp_st;
			send_request(table_rows[i].op, table_rows[i].val, table_rows[i].k,
				table_rows[i].typed, typed_ans);
		end

		// Random phases: each rewrites the dimension, loads a fresh matrix, then mixes queries with stray
		// loads and, on small matrices, full reloads. Idling modes rotate, one mode per phase.
		foreach (dim_plan[p]) begin
			write_dim(dim_plan[p]);
			case (p % 4)
				0: begin sender_idle_pct = 0;  stall_pct = 0;  end
				1: begin sender_idle_pct = 57; stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  stall_pct = 57; end
				default: begin sender_idle_pct = 23; stall_pct = 23; end
			endcase
			d      = side_len();
			budget = (d >= 8) ? 24 : 30;
			load_sorted_matrix();
			for (int n = 0; n < budget; n++) begin
				case ($urandom_range(9))
					0, 1:  send_request(OpLoad, $urandom(), 16'($urandom()), 1'b0, typed_ans);
					2: begin
						// full reloads only on small matrices
						if (d < 8)
							load_sorted_matrix();
						else begin
							k = $urandom_range(d * d + 2);
							send_request(OpQuery, $urandom(), 16'(k), 1'b0, typed_ans);
						end
					end
					3:     send_request(OpQuery, $urandom(), 16'($urandom()), 1'b0, typed_ans);
					default: begin
						k = $urandom_range(d * d + 2);
						send_request(OpQuery, $urandom(), 16'(k), 1'b0, typed_ans);
					end
				endcase
				// one mid-phase pause until the block has answered everything
				if (n == budget / 2)
					drain_results();
			end
		end

		drain_results();
		if (mismatches == 0)
			$display("kth_smallest_sorted_matrix_top verification clean");
		else
			$display("kth_smallest_sorted_matrix_top verification failed");
		$finish;
	end
endmodule
